@@ hw/rtl/npq_pkg.sv @@
// shared types and codes for the neighbour prefetch priority queue
package npq_pkg;

    // action codes of an input word
    localparam logic [2:0] ACT_ACCESS  = 3'd0;
    localparam logic [2:0] ACT_ENQUEUE = 3'd1;
    localparam logic [2:0] ACT_CANCEL  = 3'd2;
    localparam logic [2:0] ACT_FLUSH   = 3'd3;
    localparam logic [2:0] ACT_POP     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_MAX_QUEUE = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] dir_id;
        logic [15:0] file_index;
        logic [15:0] file_count;
        logic [31:0] size_hint;
        logic [7:0]  priority_req;
    } t_in;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_dir_id;
        logic [15:0] out_file_index;
        logic [31:0] out_size_hint;
        logic [7:0]  out_priority;
        logic [5:0]  queue_count;
        logic [31:0] total_popped;
    } t_out;

    // one queued request
    typedef struct packed {
        logic [15:0] dir;
        logic [15:0] idx;
        logic [31:0] size;
        logic [7:0]  prio;
    } t_entry;

endpackage

@@ hw/rtl/npq_mem.sv @@
// queue slot memory, one write port and one registered read port
module npq_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  npq_pkg::t_entry       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output npq_pkg::t_entry       o_rdata
);

    npq_pkg::t_entry r_mem [DEPTH];
    npq_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/neighbour_prefetch_priority_queue.sv @@
// Bounded prefetch request queue with neighbour scheduling, top level.
// One word is taken while busy is low; exactly one result follows, shown for a single cycle with
// o_strobe, and the receiver cannot stall it. All slot traffic goes through one single-port-write,
// registered-read memory under a small sequencer. Enqueue, flush and unknown actions go straight
// to the result, as does a record access that schedules nothing; otherwise record access steps
// through the neighbours out to the radius saturated to MAX_RADIUS. Cancel compacts the queue,
// and pop scans every slot for the minimum and then compacts the queue one slot per cycle. No
// clearing pass is needed after reset.
module neighbour_prefetch_priority_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_RADIUS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  npq_pkg::t_in   i_in,
    output logic           o_strobe,
    output npq_pkg::t_out  o_result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_RADIUS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GEN  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]      r_state, n_state;
    logic            r_enabled;
    logic [4:0]      r_radius;
    logic [5:0]      r_max_queue;
    npq_pkg::t_in    r_in, n_in;
    logic [CW-1:0]   r_occ, n_occ;
    logic [31:0]     r_total, n_total;
    logic [RW-1:0]   r_delta, n_delta;
    logic [RW-1:0]   r_rad, n_rad;
    logic            r_side, n_side;
    logic [7:0]      r_prio, n_prio;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_wp, n_wp;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_paddr, n_paddr;
    logic            r_have, n_have;
    logic [CW-1:0]   r_best, n_best;
    logic            r_cancel, n_cancel;
    npq_pkg::t_entry r_out, n_out;
    logic            r_valid, n_valid;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    npq_pkg::t_entry mem_wdata;
    npq_pkg::t_entry mem_rdata;

    logic            full;
    logic [RW-1:0]   rad_sat;
    logic [16:0]     fwd_idx;
    logic            gen_ok;
    logic            keep;
    logic            wr_cfg;

    npq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // configuration port
    assign wr_cfg = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            npq_pkg::REG_ENABLED:   prdata = {31'd0, r_enabled};
            npq_pkg::REG_RADIUS:    prdata = {27'd0, r_radius};
            npq_pkg::REG_MAX_QUEUE: prdata = {26'd0, r_max_queue};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_radius    <= 5'd2;
            r_max_queue <= 6'd32;
        end else if (wr_cfg) begin
            case (paddr[3:2])
                npq_pkg::REG_ENABLED:   r_enabled   <= pwdata[0];
                npq_pkg::REG_RADIUS:    r_radius    <= pwdata[4:0];
                npq_pkg::REG_MAX_QUEUE: r_max_queue <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // queue full against the saturated limit
    assign full = (32'(r_occ) >= 32'(r_max_queue)) || (32'(r_occ) >= QUEUE_DEPTH);
    assign rad_sat = (32'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);

    // neighbour candidate for the current step
    assign fwd_idx = {1'b0, r_in.file_index} + 17'(r_delta);
    assign gen_ok  = r_side ? (17'(r_in.file_index) >= 17'(r_delta))
                            : (fwd_idx < {1'b0, r_in.file_count});

    // compaction keeps all but the cancelled directory or the popped slot
    assign keep = r_cancel ? (mem_rdata.dir != r_in.dir_id) : (r_paddr != r_best);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_occ    = r_occ;
        n_total  = r_total;
        n_delta  = r_delta;
        n_rad    = r_rad;
        n_side   = r_side;
        n_prio   = r_prio;
        n_ptr    = r_ptr;
        n_wp     = r_wp;
        n_pend   = 1'b0;
        n_paddr  = r_ptr;
        n_have   = r_have;
        n_best   = r_best;
        n_cancel = r_cancel;
        n_out    = r_out;
        n_valid  = r_valid;
        mem_we    = 1'b0;
        mem_waddr = r_occ[AW-1:0];
        mem_wdata = '{dir: i_in.dir_id, idx: i_in.file_index,
                      size: i_in.size_hint, prio: i_in.priority_req};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in    = i_in;
                    n_out   = '0;
                    n_valid = 1'b0;
                    n_ptr   = '0;
                    n_wp    = '0;
                    n_have  = 1'b0;
                    n_state = S_DONE;
                    case (i_in.action)
                        npq_pkg::ACT_ACCESS: begin
                            if (r_enabled && i_in.file_index < i_in.file_count
                                && rad_sat != '0) begin
                                n_rad   = rad_sat;
                                n_delta = RW'(1);
                                n_side  = 1'b0;
                                n_prio  = 8'd0;
                                n_state = S_GEN;
                            end
                        end
                        npq_pkg::ACT_ENQUEUE: begin
                            if (r_enabled && !full) begin
                                mem_we = 1'b1;
                                n_occ  = r_occ + CW'(1);
                            end
                        end
                        npq_pkg::ACT_CANCEL: begin
                            n_cancel = 1'b1;
                            n_state  = S_COMP;
                        end
                        npq_pkg::ACT_FLUSH: begin
                            n_occ = '0;
                        end
                        npq_pkg::ACT_POP: begin
                            if (r_enabled && r_occ != '0) begin
                                n_cancel = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_GEN: begin
                // one neighbour per cycle, forward then backward
                mem_wdata = '{dir: r_in.dir_id,
                              idx: r_side ? (r_in.file_index - 16'(r_delta)) : fwd_idx[15:0],
                              size: r_in.size_hint, prio: r_prio};
                if (gen_ok) begin
                    n_prio = r_prio + 8'd1;
                    if (!full) begin
                        mem_we = 1'b1;
                        n_occ  = r_occ + CW'(1);
                    end
                end
                if (r_side) begin
                    n_side  = 1'b0;
                    n_delta = r_delta + RW'(1);
                    if (r_delta == r_rad) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_side = 1'b1;
                end
            end
            S_SCAN: begin
                // read every slot, keep the first lowest priority
                if (r_ptr < r_occ) begin
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                end
                if (r_pend && (!r_have || mem_rdata.prio < r_out.prio)) begin
                    n_have = 1'b1;
                    n_best = r_paddr;
                    n_out  = mem_rdata;
                end
                if (r_ptr == r_occ && !r_pend) begin
                    n_valid = 1'b1;
                    n_total = r_total + 32'd1;
                    n_ptr   = '0;
                    n_wp    = '0;
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                // stream slots down over the removed ones
                mem_waddr = r_wp[AW-1:0];
                mem_wdata = mem_rdata;
                if (r_ptr < r_occ) begin
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                end
                if (r_pend && keep) begin
                    mem_we = 1'b1;
                    n_wp   = r_wp + CW'(1);
                end
                if (r_ptr == r_occ && !r_pend) begin
                    n_occ   = r_wp;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_total <= n_total;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_delta  <= n_delta;
        r_rad    <= n_rad;
        r_side   <= n_side;
        r_prio   <= n_prio;
        r_ptr    <= n_ptr;
        r_wp     <= n_wp;
        r_paddr  <= n_paddr;
        r_have   <= n_have;
        r_best   <= n_best;
        r_cancel <= n_cancel;
        r_out    <= n_out;
    end

    // result word
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);
    assign o_result = '{out_valid:      r_valid,
                        out_dir_id:     r_out.dir,
                        out_file_index: r_out.idx,
                        out_size_hint:  r_out.size,
                        out_priority:   r_out.prio,
                        queue_count:    6'(r_occ),
                        total_popped:   r_total};

    // occupancy stays within the memory
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= QUEUE_DEPTH)
        else $error("occupancy above queue depth");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not start work");

    // ready again right after the result
    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("busy after result strobe");

    // compaction never writes ahead of the slot being read
    a_comp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) && mem_we |-> r_wp <= r_paddr)
        else $error("compaction write passed read");

    // a valid pop only ends a pop word
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.out_valid |-> r_in.action == npq_pkg::ACT_POP)
        else $error("valid result without pop");

endmodule
